// File: rtl/assert_macros.svh
// Assertion helpers for the RTL files; only the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define BVG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("battery gauge assertion failed");

// Clocked check that also holds during reset.
`define BVG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("battery gauge assertion failed");

`endif

// File: rtl/bvg_pkg.sv
`default_nettype none
package bvg_pkg;

    localparam int BATCH_SIZE_DEF = 32;
    localparam int TRIM_DEF       = 4;
    localparam int CODE_W         = 12;
    localparam int SUM_W          = 18;
    localparam int PCT_W          = 7;
    localparam int LUT_POINTS     = 12;
    localparam int DIV_NW         = 34;
    localparam int DIV_DW         = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [15:0] LUT_MV [LUT_POINTS] = '{
        16'd4190, 16'd4100, 16'd4000, 16'd3920, 16'd3850, 16'd3790,
        16'd3730, 16'd3680, 16'd3620, 16'd3500, 16'd3350, 16'd3250
    };
    localparam logic [PCT_W-1:0] LUT_PCT [LUT_POINTS] = '{
        7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd5, 7'd0
    };

    localparam logic [CFG_IDX_W-1:0] REG_DIV_NUM    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIV_DEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_NUM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_DEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_ENTER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_EXIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_ENTER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_EXIT  = 3'd7;

    typedef enum logic [1:0] {
        LVL_UNKNOWN  = 2'd0,
        LVL_NORMAL   = 2'd1,
        LVL_LOW      = 2'd2,
        LVL_CRITICAL = 2'd3
    } level_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_RANK,
        F_WRITE,
        F_SUM,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CHECK,
        B_RAW_AVG,
        B_MV_AVG,
        B_DIV_START,
        B_DIV_WAIT,
        B_MUL,
        B_CAL_START,
        B_CAL_WAIT,
        B_EMA,
        B_PCT,
        B_PCT_START,
        B_PCT_WAIT,
        B_LEVEL,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic              err;
        logic [SUM_W-1:0]  raw_sum;
        logic [SUM_W-1:0]  mv_sum;
        logic [CODE_W-1:0] raw_min;
        logic [CODE_W-1:0] raw_max;
    } batch_sum_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef struct packed {
        logic [4:0]       div_num;
        logic [4:0]       div_den;
        logic [15:0]      cal_num;
        logic [15:0]      cal_den;
        logic [PCT_W-1:0] low_enter;
        logic [PCT_W-1:0] low_exit;
        logic [PCT_W-1:0] crit_enter;
        logic [PCT_W-1:0] crit_exit;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } div_res_t;

endpackage
`default_nettype wire

// File: rtl/bvg_ram.sv
`default_nettype none
module bvg_ram #(
    parameter int W = 8,
    parameter int D = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 we,
    input  wire logic [$clog2(D)-1:0] waddr,
    input  wire logic [W-1:0]         wdata,
    input  wire logic [$clog2(D)-1:0] raddr,
    output logic      [W-1:0]         rdata
);
    logic [W-1:0] mem_reg [D];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/bvg_div.sv
`default_nettype none
module bvg_div import bvg_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire div_req_t req,
    output div_res_t      res
);
    localparam int CW = $clog2(DIV_NW + 1);

    logic              busy_reg, done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg, den_reg;
    logic [DIV_DW:0]   rem_sh, diff;
    logic              ge;

    assign rem_sh = {rem_reg, quo_reg[DIV_NW-1]};
    assign diff   = rem_sh - {1'b0, den_reg};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (req.start) begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CW'(DIV_NW);
                    quo_reg  <= req.num;
                    rem_reg  <= '0;
                    den_reg  <= req.den;
                end
            end else begin
                quo_reg <= {quo_reg[DIV_NW-2:0], ge};
                rem_reg <= ge ? diff[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.quo  = quo_reg;
endmodule
`default_nettype wire

// File: rtl/bvg_fifo.sv
`default_nettype none
module bvg_fifo import bvg_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire batch_sum_t push_data,
    input  wire logic       pop,
    output batch_sum_t      pop_data,
    output fifo_status_t    status
);
    batch_sum_t mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                mem_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = cnt_reg == 2'd2;
    assign status.empty = cnt_reg == 2'd0;
endmodule
`default_nettype wire

// File: rtl/bvg_front.sv
`default_nettype none
module bvg_front import bvg_pkg::*; #(
    parameter int BATCH_SIZE    = BATCH_SIZE_DEF,
    parameter int TRIM_EACH_END = TRIM_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CODE_W-1:0] s_raw_code,
    input  wire logic [CODE_W-1:0] s_sample_mv,
    input  wire logic              s_sample_error,
    input  wire fifo_status_t      fifo_st,
    output logic                   push,
    output batch_sum_t             push_data
);
    localparam int IW       = $clog2(BATCH_SIZE);
    localparam int CW       = IW + 1;
    localparam int TRIM_MAX = (BATCH_SIZE - 1) / 2;
    localparam int TRIM_EFF = (TRIM_EACH_END > TRIM_MAX) ? TRIM_MAX : TRIM_EACH_END;
    localparam int KEEP_HI  = BATCH_SIZE - TRIM_EFF;
    localparam int WW       = 2 * CODE_W + IW;

    front_state_t      state_reg, state_next;
    logic [IW-1:0]     k_reg, rd_idx_reg, new_rank_reg;
    logic [CW-1:0]     j_reg;
    logic              rd_vld_reg, rd_vld_next, err_reg;
    logic [CODE_W-1:0] new_raw_reg, new_mv_reg, min_reg, max_reg;
    logic [SUM_W-1:0]  raw_sum_reg, mv_sum_reg;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    logic [WW-1:0]     ram_wdata, ram_rdata;
    logic [CODE_W-1:0] rd_raw, rd_mv;
    logic [IW-1:0]     rd_rank;
    logic              accept, older_above, kept;

    // Each entry holds a sample and its current rank among the batch so far.
    bvg_ram #(.W(WW), .D(BATCH_SIZE)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_raw      = ram_rdata[WW-1 -: CODE_W];
    assign rd_mv       = ram_rdata[IW +: CODE_W];
    assign rd_rank     = ram_rdata[IW-1:0];
    assign accept      = s_valid && s_ready;
    assign older_above = rd_raw > new_raw_reg;
    assign kept        = ({1'b0, rd_rank} >= CW'(TRIM_EFF)) && ({1'b0, rd_rank} < CW'(KEEP_HI));
    assign rd_vld_next = ((state_reg == F_RANK) && (j_reg < {1'b0, k_reg}))
                      || ((state_reg == F_SUM) && (j_reg < CW'(BATCH_SIZE)));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:  if (accept) state_next = F_RANK;
            F_RANK:  if ((j_reg == {1'b0, k_reg}) && !rd_vld_reg) state_next = F_WRITE;
            F_WRITE: state_next = (k_reg == IW'(BATCH_SIZE - 1)) ? F_SUM : F_IDLE;
            F_SUM:   if ((j_reg == CW'(BATCH_SIZE)) && !rd_vld_reg) state_next = F_PUSH;
            F_PUSH:  if (!fifo_st.full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        push      = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = j_reg[IW-1:0];
        ram_waddr = rd_idx_reg;
        ram_wdata = {rd_raw, rd_mv, rd_rank + IW'(1)};
        unique case (state_reg)
            F_IDLE:  s_ready = 1'b1;
            // An older entry with a larger code moves one place up.
            F_RANK:  ram_we = rd_vld_reg && older_above;
            F_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = {new_raw_reg, new_mv_reg, new_rank_reg};
            end
            F_SUM:   ;
            F_PUSH:  push = !fifo_st.full;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            k_reg        <= '0;
            j_reg        <= '0;
            rd_vld_reg   <= 1'b0;
            err_reg      <= 1'b0;
            new_rank_reg <= '0;
            raw_sum_reg  <= '0;
            mv_sum_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
            rd_idx_reg <= j_reg[IW-1:0];
            unique case (state_reg)
                F_IDLE: begin
                    if (accept) begin
                        new_raw_reg  <= s_raw_code;
                        new_mv_reg   <= s_sample_mv;
                        new_rank_reg <= '0;
                        j_reg        <= '0;
                        err_reg      <= err_reg | s_sample_error;
                    end
                end
                F_RANK: begin
                    if (j_reg < {1'b0, k_reg}) j_reg <= j_reg + CW'(1);
                    // Equal codes keep arrival order, so the new sample ranks after them.
                    if (rd_vld_reg && !older_above) new_rank_reg <= new_rank_reg + IW'(1);
                end
                F_WRITE: begin
                    if (k_reg == IW'(BATCH_SIZE - 1)) j_reg <= '0;
                    else k_reg <= k_reg + IW'(1);
                end
                F_SUM: begin
                    if (j_reg < CW'(BATCH_SIZE)) j_reg <= j_reg + CW'(1);
                    if (rd_vld_reg) begin
                        if (kept) begin
                            raw_sum_reg <= raw_sum_reg + SUM_W'(rd_raw);
                            mv_sum_reg  <= mv_sum_reg + SUM_W'(rd_mv);
                        end
                        if (rd_rank == '0) min_reg <= rd_raw;
                        if (rd_rank == IW'(BATCH_SIZE - 1)) max_reg <= rd_raw;
                    end
                end
                F_PUSH: begin
                    if (!fifo_st.full) begin
                        k_reg       <= '0;
                        err_reg     <= 1'b0;
                        raw_sum_reg <= '0;
                        mv_sum_reg  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign push_data.err     = err_reg;
    assign push_data.raw_sum = raw_sum_reg;
    assign push_data.mv_sum  = mv_sum_reg;
    assign push_data.raw_min = min_reg;
    assign push_data.raw_max = max_reg;
endmodule
`default_nettype wire

// File: rtl/bvg_back.sv
`default_nettype none
module bvg_back import bvg_pkg::*; #(
    parameter int BATCH_SIZE    = BATCH_SIZE_DEF,
    parameter int TRIM_EACH_END = TRIM_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire cfg_t         cfg,
    input  wire fifo_status_t fifo_st,
    input  wire batch_sum_t   pop_data,
    output logic              pop,
    output div_req_t          div_req,
    input  wire div_res_t     div_res,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic              m_status,
    output logic [11:0]       m_raw_mean,
    output logic [11:0]       m_raw_min,
    output logic [11:0]       m_raw_max,
    output logic [11:0]       m_adc_mv,
    output logic [15:0]       m_pack_mv,
    output logic [15:0]       m_smooth_mv,
    output logic [6:0]        m_percent,
    output logic [1:0]        m_level_state,
    output logic              m_level_changed,
    output logic [31:0]       m_sequence_res
);
    localparam int TRIM_MAX = (BATCH_SIZE - 1) / 2;
    localparam int TRIM_EFF = (TRIM_EACH_END > TRIM_MAX) ? TRIM_MAX : TRIM_EACH_END;
    localparam int KEEP     = BATCH_SIZE - 2 * TRIM_EFF;
    localparam int AVG_SH   = SUM_W + $clog2(KEEP);
    localparam int PROD_W   = 2 * SUM_W + 1;
    localparam longint unsigned AVG_MUL =
        ((64'd1 << AVG_SH) + 64'(KEEP) - 64'd1) / 64'(KEEP);

    back_state_t       state_reg, state_next;
    batch_sum_t        sum_reg;
    logic [11:0]       raw_avg_reg, adc_reg;
    logic [16:0]       b1_reg;
    logic [32:0]       prod_reg;
    logic [31:0]       batt_reg, filt_reg, cnt_reg;
    logic [6:0]        pct_reg, pct_base_reg;
    logic [15:0]       pct_num_reg, pct_den_reg;
    level_t            level_reg, lvl_nx;
    logic [34:0]       ema_sum;
    logic [4:0]        dd1;
    logic [15:0]       dd2;
    logic              seg_found, seg_top, seg_bottom;
    logic [3:0]        seg;
    logic [7:0]        pct_sum;
    logic [SUM_W-1:0]  avg_num;
    logic [PROD_W-1:0] avg_prod;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        sat16 = (v > 32'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic level_t next_level(input level_t cur, input logic [6:0] pct,
                                          input cfg_t c);
        priority if (cur == LVL_CRITICAL && pct < c.low_exit)
            next_level = (pct >= c.crit_exit) ? LVL_LOW : LVL_CRITICAL;
        else if (cur == LVL_LOW && pct < c.low_exit)
            next_level = (pct <= c.crit_enter) ? LVL_CRITICAL : LVL_LOW;
        else if (pct <= c.crit_enter)
            next_level = LVL_CRITICAL;
        else if (pct <= c.low_enter)
            next_level = LVL_LOW;
        else
            next_level = LVL_NORMAL;
    endfunction

    assign dd1     = (cfg.div_den == 5'd0) ? 5'd1 : cfg.div_den;
    assign dd2     = (cfg.cal_den == 16'd0) ? 16'd1 : cfg.cal_den;
    assign ema_sum = ({filt_reg, 3'd0} - 35'(filt_reg)) + 35'(batt_reg) + 35'd4;
    assign lvl_nx  = next_level(level_reg, pct_reg, cfg);
    assign pct_sum = 8'(pct_base_reg) + div_res.quo[7:0];

    // The rounded mean divides by a constant, so it is a multiplication by a rounded-up
    // reciprocal of KEEP; the shift is wide enough to be exact over the whole sum range.
    assign avg_num  = ((state_reg == B_MV_AVG) ? sum_reg.mv_sum : sum_reg.raw_sum)
                    + SUM_W'(KEEP / 2);
    assign avg_prod = PROD_W'(avg_num) * PROD_W'(AVG_MUL);

    // Table segment that holds the filtered voltage; of several matches the lowest index wins.
    always_comb begin
        seg_top    = filt_reg >= 32'(LUT_MV[0]);
        seg_bottom = filt_reg <= 32'(LUT_MV[LUT_POINTS-1]);
        seg_found  = 1'b0;
        seg        = '0;
        for (int i = LUT_POINTS - 2; i >= 0; i--) begin
            if (filt_reg <= 32'(LUT_MV[i]) && filt_reg >= 32'(LUT_MV[i+1])) begin
                seg_found = 1'b1;
                seg       = 4'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:      if (!fifo_st.empty) state_next = B_CHECK;
            B_CHECK:     state_next = sum_reg.err ? B_OUT : B_RAW_AVG;
            B_RAW_AVG:   state_next = B_MV_AVG;
            B_MV_AVG:    state_next = B_DIV_START;
            B_DIV_START: state_next = B_DIV_WAIT;
            B_DIV_WAIT:  if (div_res.done) state_next = B_MUL;
            B_MUL:       state_next = B_CAL_START;
            B_CAL_START: state_next = B_CAL_WAIT;
            B_CAL_WAIT:  if (div_res.done) state_next = B_EMA;
            B_EMA:       state_next = B_PCT;
            B_PCT:       state_next = (seg_top || seg_bottom || !seg_found) ? B_LEVEL
                                                                          : B_PCT_START;
            B_PCT_START: state_next = B_PCT_WAIT;
            B_PCT_WAIT:  if (div_res.done) state_next = B_LEVEL;
            B_LEVEL:     state_next = B_OUT;
            B_OUT:       if (m_ready) state_next = B_IDLE;
            default:     state_next = B_IDLE;
        endcase
    end

    always_comb begin
        pop           = 1'b0;
        m_valid       = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        unique case (state_reg)
            B_IDLE:      pop = !fifo_st.empty;
            B_DIV_START: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'({5'd0, adc_reg} * {12'd0, cfg.div_num})
                              + DIV_NW'(dd1 >> 1);
                div_req.den   = DIV_DW'(dd1);
            end
            B_CAL_START: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(prod_reg) + DIV_NW'(dd2 >> 1);
                div_req.den   = dd2;
            end
            B_PCT_START: begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'(pct_num_reg);
                div_req.den   = pct_den_reg;
            end
            B_OUT:       m_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            filt_reg  <= '0;
            level_reg <= LVL_UNKNOWN;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                B_IDLE:     if (!fifo_st.empty) sum_reg <= pop_data;
                B_CHECK: begin
                    if (sum_reg.err) begin
                        m_status        <= 1'b1;
                        m_raw_mean      <= '0;
                        m_raw_min       <= '0;
                        m_raw_max       <= '0;
                        m_adc_mv        <= '0;
                        m_pack_mv       <= '0;
                        m_smooth_mv     <= '0;
                        m_percent       <= '0;
                        m_level_state   <= level_reg;
                        m_level_changed <= 1'b0;
                        m_sequence_res  <= cnt_reg;
                    end
                end
                B_RAW_AVG:  raw_avg_reg <= avg_prod[AVG_SH +: CODE_W];
                B_MV_AVG:   adc_reg <= avg_prod[AVG_SH +: CODE_W];
                B_DIV_WAIT: if (div_res.done) b1_reg <= div_res.quo[16:0];
                B_MUL:      prod_reg <= 33'(b1_reg) * 33'(cfg.cal_num);
                B_CAL_WAIT: begin
                    if (div_res.done) begin
                        batt_reg <= (div_res.quo[DIV_NW-1:32] != '0) ? 32'hFFFF_FFFF
                                                                     : div_res.quo[31:0];
                    end
                end
                // An unseeded average (zero) takes the batch voltage as it is.
                B_EMA:      filt_reg <= (filt_reg == 32'd0) ? batt_reg : ema_sum[34:3];
                B_PCT: begin
                    pct_base_reg <= LUT_PCT[seg + 4'd1];
                    pct_num_reg  <= 16'(8'(filt_reg[15:0] - LUT_MV[seg + 4'd1]))
                                  * 16'(LUT_PCT[seg] - LUT_PCT[seg + 4'd1])
                                  + ((LUT_MV[seg] - LUT_MV[seg + 4'd1]) >> 1);
                    pct_den_reg  <= LUT_MV[seg] - LUT_MV[seg + 4'd1];
                    if (seg_top) pct_reg <= LUT_PCT[0];
                    else if (seg_bottom || !seg_found) pct_reg <= LUT_PCT[LUT_POINTS-1];
                end
                B_PCT_WAIT: begin
                    if (div_res.done) pct_reg <= (pct_sum > 8'd100) ? 7'd100 : pct_sum[6:0];
                end
                B_LEVEL: begin
                    level_reg       <= lvl_nx;
                    cnt_reg         <= cnt_reg + 32'd1;
                    m_status        <= 1'b0;
                    m_raw_mean      <= raw_avg_reg;
                    m_raw_min       <= sum_reg.raw_min;
                    m_raw_max       <= sum_reg.raw_max;
                    m_adc_mv        <= adc_reg;
                    m_pack_mv       <= sat16(batt_reg);
                    m_smooth_mv     <= sat16(filt_reg);
                    m_percent       <= pct_reg;
                    m_level_state   <= lvl_nx;
                    m_level_changed <= lvl_nx != level_reg;
                    m_sequence_res  <= cnt_reg + 32'd1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/battery_voltage_gauge.sv
`default_nettype none
`include "assert_macros.svh"
// Battery voltage gauge. Samples (raw code, millivolts, error flag) arrive as requests on the
// s_ channel; every BATCH_SIZE samples give one result request on the m_ channel. Sample k of a
// batch (k counted from 0) is ranked against the k samples stored before it, one stored entry
// per cycle through the sample memory's single read port, and the input is not ready again
// until that sample is written back; the last sample of a batch adds a sweep over the whole
// memory that forms the trimmed sums, after which the batch summary enters a two-entry queue.
// The back end then spends most of each batch in up to three passes of a 34-step shared
// divider, and runs in parallel with the collection of the next batch. Configuration must be
// written through cfg_we, cfg_index and cfg_data only while no batch is in flight; the block
// does not enforce this. Zero denominators act as one.
module battery_voltage_gauge import bvg_pkg::*; #(
    parameter int BATCH_SIZE    = BATCH_SIZE_DEF,
    parameter int TRIM_EACH_END = TRIM_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [11:0]           s_raw_code,
    input  wire logic [11:0]           s_sample_mv,
    input  wire logic                  s_sample_error,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_status,
    output logic [11:0]                m_raw_mean,
    output logic [11:0]                m_raw_min,
    output logic [11:0]                m_raw_max,
    output logic [11:0]                m_adc_mv,
    output logic [15:0]                m_pack_mv,
    output logic [15:0]                m_smooth_mv,
    output logic [6:0]                 m_percent,
    output logic [1:0]                 m_level_state,
    output logic                       m_level_changed,
    output logic [31:0]                m_sequence_res
);
    cfg_t         cfg_reg;
    fifo_status_t fifo_st;
    batch_sum_t   push_data, pop_data;
    logic         push, pop;
    div_req_t     div_req;
    div_res_t     div_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.div_num    <= 5'd2;
            cfg_reg.div_den    <= 5'd1;
            cfg_reg.cal_num    <= 16'd10000;
            cfg_reg.cal_den    <= 16'd10000;
            cfg_reg.low_enter  <= 7'd15;
            cfg_reg.low_exit   <= 7'd17;
            cfg_reg.crit_enter <= 7'd5;
            cfg_reg.crit_exit  <= 7'd7;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DIV_NUM:    cfg_reg.div_num    <= cfg_data[4:0];
                REG_DIV_DEN:    cfg_reg.div_den    <= cfg_data[4:0];
                REG_CAL_NUM:    cfg_reg.cal_num    <= cfg_data;
                REG_CAL_DEN:    cfg_reg.cal_den    <= cfg_data;
                REG_LOW_ENTER:  cfg_reg.low_enter  <= cfg_data[6:0];
                REG_LOW_EXIT:   cfg_reg.low_exit   <= cfg_data[6:0];
                REG_CRIT_ENTER: cfg_reg.crit_enter <= cfg_data[6:0];
                REG_CRIT_EXIT:  cfg_reg.crit_exit  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    bvg_front #(.BATCH_SIZE(BATCH_SIZE), .TRIM_EACH_END(TRIM_EACH_END)) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_raw_code     (s_raw_code),
        .s_sample_mv    (s_sample_mv),
        .s_sample_error (s_sample_error),
        .fifo_st        (fifo_st),
        .push           (push),
        .push_data      (push_data)
    );

    bvg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (fifo_st)
    );

    bvg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .res     (div_res)
    );

    bvg_back #(.BATCH_SIZE(BATCH_SIZE), .TRIM_EACH_END(TRIM_EACH_END)) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .fifo_st         (fifo_st),
        .pop_data        (pop_data),
        .pop             (pop),
        .div_req         (div_req),
        .div_res         (div_res),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_raw_mean      (m_raw_mean),
        .m_raw_min       (m_raw_min),
        .m_raw_max       (m_raw_max),
        .m_adc_mv        (m_adc_mv),
        .m_pack_mv       (m_pack_mv),
        .m_smooth_mv     (m_smooth_mv),
        .m_percent       (m_percent),
        .m_level_state   (m_level_state),
        .m_level_changed (m_level_changed),
        .m_sequence_res  (m_sequence_res)
    );

    `BVG_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid)
    `BVG_ASSERT(a_fifo_flags, aclk, aresetn, !(fifo_st.full && fifo_st.empty))
    `BVG_ASSERT(a_abort_clear, aclk, aresetn, (m_valid && m_status) |-> (m_smooth_mv == 16'd0))
    `BVG_ASSERT(a_pct_range, aclk, aresetn, (m_valid && !m_status) |-> (m_percent <= 7'd100))
    `BVG_ASSERT(a_min_max, aclk, aresetn, ($rose(m_valid) && !m_status) |-> (m_raw_min <= m_raw_max))
endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import bvg_pkg::*;

    localparam int BATCH     = 32;
    localparam int TRIM      = 4;
    localparam int KEEP      = BATCH - 2 * TRIM;
    localparam int WATCHDOG  = 8000;
    localparam int DRAIN     = 400;

    typedef struct packed {
        logic [11:0] raw;
        logic [11:0] mv;
        logic        err;
    } sample_t;

    typedef struct packed {
        logic        status;
        logic [11:0] raw_mean;
        logic [11:0] raw_min;
        logic [11:0] raw_max;
        logic [11:0] adc_mv;
        logic [15:0] pack_mv;
        logic [15:0] smooth_mv;
        logic [6:0]  percent;
        logic [1:0]  level_state;
        logic        level_changed;
        logic [31:0] sequence_res;
    } gauge_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [11:0]           s_raw_code;
    logic [11:0]           s_sample_mv;
    logic                  s_sample_error;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_status;
    logic [11:0]           m_raw_mean;
    logic [11:0]           m_raw_min;
    logic [11:0]           m_raw_max;
    logic [11:0]           m_adc_mv;
    logic [15:0]           m_pack_mv;
    logic [15:0]           m_smooth_mv;
    logic [6:0]            m_percent;
    logic [1:0]            m_level_state;
    logic                  m_level_changed;
    logic [31:0]           m_sequence_res;

    battery_voltage_gauge dut (.*);

    sample_t       sample_q[$];
    gauge_result_t gauge_q[$];
    int            mismatches = 0;
    int            send_idle = 0;
    int            recv_stall = 0;
    logic          s_fire = 1'b0;
    int            quiet_cycles = 0;

    // Shadow of the block's state and registers.
    logic [11:0] store_raw [BATCH];
    logic [11:0] store_mv  [BATCH];
    int          fill = 0;
    logic        batch_err = 1'b0;
    logic [31:0] filt_v = '0;
    level_t      level = LVL_UNKNOWN;
    logic [31:0] good_batches = '0;
    logic [4:0]  c_div_num = 5'd2, c_div_den = 5'd1;
    logic [15:0] c_cal_num = 16'd10000, c_cal_den = 16'd10000;
    logic [6:0]  c_low_enter = 7'd15, c_low_exit = 7'd17;
    logic [6:0]  c_crit_enter = 7'd5, c_crit_exit = 7'd7;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
        longint unsigned dd;
        dd = (d == 0) ? 1 : d;
        return (n + dd / 2) / dd;
    endfunction

    function automatic logic [6:0] charge_of(logic [31:0] mv);
        int unsigned hi, lo, vspan, pspan;
        if (mv >= LUT_MV[0]) return LUT_PCT[0];
        if (mv <= LUT_MV[LUT_POINTS-1]) return LUT_PCT[LUT_POINTS-1];
        for (int i = 0; i < LUT_POINTS - 1; i++) begin
            hi = LUT_MV[i];
            lo = LUT_MV[i+1];
            if (mv <= hi && mv >= lo) begin
                vspan = hi - lo;
                pspan = LUT_PCT[i] - LUT_PCT[i+1];
                return 7'(LUT_PCT[i+1] + ((mv - lo) * pspan + vspan / 2) / vspan);
            end
        end
        return 7'd0;
    endfunction

    function automatic level_t level_after(level_t cur, logic [6:0] pct);
        if (cur == LVL_CRITICAL && pct < c_low_exit)
            return (pct >= c_crit_exit) ? LVL_LOW : LVL_CRITICAL;
        if (cur == LVL_LOW && pct < c_low_exit)
            return (pct <= c_crit_enter) ? LVL_CRITICAL : LVL_LOW;
        if (pct <= c_crit_enter) return LVL_CRITICAL;
        if (pct <= c_low_enter) return LVL_LOW;
        return LVL_NORMAL;
    endfunction

    task automatic gauge_sample(sample_t smp);
        gauge_result_t   r;
        logic [11:0]     sr [BATCH];
        logic [11:0]     sm [BATCH];
        logic [11:0]     kr, km;
        int              j;
        longint unsigned raw_sum, mv_sum, adc, batt;
        logic [6:0]      pct;
        level_t          nxt;
        store_raw[fill] = smp.raw;
        store_mv[fill]  = smp.mv;
        if (smp.err) batch_err = 1'b1;
        fill++;
        if (fill < BATCH) return;
        fill = 0;
        r = '0;
        if (batch_err) begin
            batch_err = 1'b0;
            r.status = 1'b1;
            r.level_state = level;
            r.sequence_res = good_batches;
            gauge_q.push_back(r);
            return;
        end
        // Stable sort keeps millivolts paired with equal raw codes in arrival order.
        sr = store_raw;
        sm = store_mv;
        for (int i = 1; i < BATCH; i++) begin
            kr = sr[i];
            km = sm[i];
            j = i;
            while (j > 0 && sr[j-1] > kr) begin
                sr[j] = sr[j-1];
                sm[j] = sm[j-1];
                j--;
            end
            sr[j] = kr;
            sm[j] = km;
        end
        raw_sum = 0;
        mv_sum = 0;
        for (int i = TRIM; i < BATCH - TRIM; i++) begin
            raw_sum += sr[i];
            mv_sum += sm[i];
        end
        adc = round_div(mv_sum, KEEP);
        batt = round_div(adc * c_div_num, c_div_den);
        batt = round_div(batt * c_cal_num, c_cal_den);
        if (batt > 64'hFFFF_FFFF) batt = 64'hFFFF_FFFF;
        if (filt_v == 0) filt_v = batt[31:0];
        else filt_v = 32'((longint'(filt_v) * 7 + batt + 4) / 8);
        pct = charge_of(filt_v);
        good_batches++;
        nxt = level_after(level, pct);
        r.raw_mean = 12'(round_div(raw_sum, KEEP));
        r.raw_min = sr[0];
        r.raw_max = sr[BATCH-1];
        r.adc_mv = 12'(adc);
        r.pack_mv = (batt > 65535) ? 16'hFFFF : 16'(batt);
        r.smooth_mv = (filt_v > 65535) ? 16'hFFFF : filt_v[15:0];
        r.percent = pct;
        r.level_state = nxt;
        r.level_changed = (nxt != level);
        r.sequence_res = good_batches;
        level = nxt;
        gauge_q.push_back(r);
    endtask

    task automatic report(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic check_field(string what, longint unsigned got, longint unsigned want);
        if (got !== want) report(what, got, want);
    endtask

    // Sampling at the rising edge: predict on accepted samples, check accepted results.
    always @(posedge aclk) begin
        gauge_result_t w;
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            gauge_sample('{raw: s_raw_code, mv: s_sample_mv, err: s_sample_error});
        if (aresetn && m_valid && m_ready) begin
            if (gauge_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                w = gauge_q.pop_front();
                check_field("status", m_status, w.status);
                check_field("raw_mean", m_raw_mean, w.raw_mean);
                check_field("raw_min", m_raw_min, w.raw_min);
                check_field("raw_max", m_raw_max, w.raw_max);
                check_field("adc_mv", m_adc_mv, w.adc_mv);
                check_field("pack_mv", m_pack_mv, w.pack_mv);
                check_field("smooth_mv", m_smooth_mv, w.smooth_mv);
                check_field("percent", m_percent, w.percent);
                check_field("level_state", m_level_state, w.level_state);
                check_field("level_changed", m_level_changed, w.level_changed);
                check_field("sequence_res", m_sequence_res, w.sequence_res);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (sample_q.size() == 0 && !s_valid && gauge_q.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sample driver: a request is held until accepted, then maybe a gap.
    always @(negedge aclk) begin
        sample_t nx;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_fire) begin
            s_valid <= 1'b1;
        end else if (sample_q.size() != 0 && $urandom_range(99) >= send_idle) begin
            nx = sample_q.pop_front();
            s_raw_code <= nx.raw;
            s_sample_mv <= nx.mv;
            s_sample_error <= nx.err;
            s_valid <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_stall);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            REG_DIV_NUM:    c_div_num = val[4:0];
            REG_DIV_DEN:    c_div_den = val[4:0];
            REG_CAL_NUM:    c_cal_num = val;
            REG_CAL_DEN:    c_cal_den = val;
            REG_LOW_ENTER:  c_low_enter = val[6:0];
            REG_LOW_EXIT:   c_low_exit = val[6:0];
            REG_CRIT_ENTER: c_crit_enter = val[6:0];
            default:        c_crit_exit = val[6:0];
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic write_all(int dn, int dd, int cn, int cd, int le, int lx, int ce, int cx);
        write_reg(REG_DIV_NUM, CFG_DATA_W'(dn));
        write_reg(REG_DIV_DEN, CFG_DATA_W'(dd));
        write_reg(REG_CAL_NUM, CFG_DATA_W'(cn));
        write_reg(REG_CAL_DEN, CFG_DATA_W'(cd));
        write_reg(REG_LOW_ENTER, CFG_DATA_W'(le));
        write_reg(REG_LOW_EXIT, CFG_DATA_W'(lx));
        write_reg(REG_CRIT_ENTER, CFG_DATA_W'(ce));
        write_reg(REG_CRIT_EXIT, CFG_DATA_W'(cx));
    endtask

    // Batch shapes: 0 realistic, 1 any value, 2 one failed sample, 3 extremes,
    // 4 few distinct codes, 5 all millivolts zero.
    task automatic queue_batch(int shape);
        sample_t s;
        int      bad;
        int      base;
        bad = $urandom_range(BATCH - 1);
        base = $urandom_range(4095);
        for (int i = 0; i < BATCH; i++) begin
            s.raw = 12'($urandom_range(4095));
            s.mv = 12'($urandom_range(4095));
            s.err = 1'b0;
            case (shape)
                0: s.mv = 12'($urandom_range(1550, 2150));
                2: s.err = (i == bad);
                3: begin
                    s.raw = $urandom_range(1) ? 12'hFFF : 12'h000;
                    s.mv = $urandom_range(1) ? 12'hFFF : 12'h000;
                end
                4: s.raw = 12'(base + $urandom_range(3));
                5: s.mv = 12'h000;
                default: ;
            endcase
            sample_q.push_back(s);
        end
    endtask

    task automatic drain;
        while (sample_q.size() != 0 || s_valid || gauge_q.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    initial begin
        int pick;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_raw_code = '0;
        s_sample_mv = '0;
        s_sample_error = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: unseeded zero voltage, extremes, an aborted batch, equal codes.
        queue_batch(5);
        queue_batch(3);
        queue_batch(2);
        queue_batch(4);
        queue_batch(0);
        drain();
        write_all(31, 0, 65535, 0, 0, 0, 0, 0);
        queue_batch(3);
        queue_batch(1);
        drain();
        write_all(1, 16, 1, 65535, 127, 127, 127, 127);
        queue_batch(0);
        queue_batch(1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 74; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 74; end
                default: begin send_idle = 18; recv_stall = 18; end
            endcase
            if (ph % 2 == 0)
                write_all(2, 1, 10000, 10000, $urandom_range(10, 30), $urandom_range(10, 35),
                          $urandom_range(0, 12), $urandom_range(0, 15));
            else
                write_all($urandom_range(31), $urandom_range(31), $urandom_range(65535),
                          $urandom_range(65535), $urandom_range(127), $urandom_range(127),
                          $urandom_range(127), $urandom_range(127));
            for (int b = 0; b < 2 + ph % 2; b++) begin
                pick = $urandom_range(99);
                if (pick < 55) queue_batch(0);
                else if (pick < 70) queue_batch(1);
                else if (pick < 80) queue_batch(2);
                else if (pick < 90) queue_batch(4);
                else if (pick < 96) queue_batch(3);
                else queue_batch(5);
            end
            drain();
        end

        if (mismatches == 0 && gauge_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
